/* src/fixed_point_q24_8_alu_defines.svh */
// Assertion macros used by the checker file.
`ifndef FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FXA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication checked outside reset.
`define FXA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

/* src/fxalu_pkg.sv */
package fxalu_pkg;

  localparam int FracBitsDefault = 8;
  localparam int DataW           = 32;
  localparam int IntPartW        = 24;
  localparam int CmdW            = 4;
  // divide numerator width at the default fraction width
  localparam int DivW            = DataW + FracBitsDefault + 1;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_MIN  = 4'd4,
    CMD_MAX  = 4'd5,
    CMD_INC  = 4'd6,
    CMD_DEC  = 4'd7,
    CMD_FINT = 4'd8
  } cmd_t;

  // Side information that rides with an item through the pipeline.
  typedef struct packed {
    logic [CmdW-1:0]        cmd;
    logic [DataW-1:0]       simple_res;  // result of the non-mul/div commands
    logic                   simple_sat;
    logic                   gt;
    logic                   lt;
    logic                   eq;
    logic [IntPartW-1:0]    int_part;
    logic                   neg;         // sign of a mul or div result
    logic                   dz;
  } fxa_side_t;

endpackage

/* src/fixed_point_q24_8_alu.sv */
// Signed fixed-point ALU (Q24.8 by default). One request per cycle is taken
// while the output is not stalled; out_tvalid for it comes through the stage-1
// registers, the divider, which resolves one quotient bit per pipeline stage
// over 33+FRAC_BITS stages, and the output register. Multiply and divide round to
// nearest, ties away from zero; overflow saturates and sets saturated; divide
// by zero returns zero with divide_by_zero set.
// The whole pipeline holds while out_tready is low with a result waiting.
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = fxalu_pkg::FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // command[3:0], operand_a[35:4], operand_b[67:36]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // result[31:0], a_greater, a_less, a_equal,
                                  // integer_part[58:35], divide_by_zero, saturated
);
  localparam int W    = fxalu_pkg::DataW;
  localparam int DW   = W + FRAC_BITS + 1;

  logic en;
  // pipeline advances unless a result waits at the output
  assign en        = !(out_tvalid && !out_tready);
  assign in_tready = en;

  // stage 0: decode, simple ops, flags
  logic [3:0]        cmd;
  logic signed [W-1:0] a, b;
  assign cmd = in_tdata[3:0];
  assign a   = in_tdata[35:4];
  assign b   = in_tdata[67:36];

  fxalu_pkg::fxa_side_t side0;
  logic [W-1:0] ma, mb;
  logic signed [W:0] sum, dif, inc1, dec1;
  logic signed [W+16:0] fint;
  logic signed [W-1:0] ipart;

  always_comb begin
    ma   = a[W-1] ? W'(-a) : a;
    mb   = b[W-1] ? W'(-b) : b;
    sum  = {a[W-1], a} + {b[W-1], b};
    dif  = {a[W-1], a} - {b[W-1], b};
    inc1 = {a[W-1], a} + (W+1)'(1);
    dec1 = {a[W-1], a} - (W+1)'(1);
    fint = (W+17)'(a) <<< FRAC_BITS;
    ipart = W'(ma >> FRAC_BITS);
    if (a[W-1]) ipart = -ipart;
    side0 = '0;
    side0.cmd      = cmd;
    side0.gt       = a > b;
    side0.lt       = a < b;
    side0.eq       = a == b;
    side0.int_part = ipart[fxalu_pkg::IntPartW-1:0];
    case (cmd)
      fxalu_pkg::CMD_ADD:  {side0.simple_sat, side0.simple_res} =
                             (sum[W] != sum[W-1]) ? {1'b1, sum[W] ? 32'h80000000 : 32'h7fffffff}
                                                  : {1'b0, sum[W-1:0]};
      fxalu_pkg::CMD_SUB:  {side0.simple_sat, side0.simple_res} =
                             (dif[W] != dif[W-1]) ? {1'b1, dif[W] ? 32'h80000000 : 32'h7fffffff}
                                                  : {1'b0, dif[W-1:0]};
      fxalu_pkg::CMD_INC:  {side0.simple_sat, side0.simple_res} =
                             (inc1[W] != inc1[W-1]) ? {1'b1, 32'h7fffffff} : {1'b0, inc1[W-1:0]};
      fxalu_pkg::CMD_DEC:  {side0.simple_sat, side0.simple_res} =
                             (dec1[W] != dec1[W-1]) ? {1'b1, 32'h80000000} : {1'b0, dec1[W-1:0]};
      fxalu_pkg::CMD_MIN:  side0.simple_res = side0.lt ? a : b;
      fxalu_pkg::CMD_MAX:  side0.simple_res = side0.gt ? a : b;
      fxalu_pkg::CMD_FINT: begin
        if (fint > (W+17)'(signed'(32'h7fffffff))) begin
          side0.simple_sat = 1'b1;
          side0.simple_res = 32'h7fffffff;
        end else if (fint < -(W+17)'(33'sh80000000)) begin
          side0.simple_sat = 1'b1;
          side0.simple_res = 32'h80000000;
        end else begin
          side0.simple_res = fint[W-1:0];
        end
      end
      default: ;
    endcase
    side0.neg = (cmd == fxalu_pkg::CMD_MUL) ? (a[W-1] ^ b[W-1]) && (a != 0) && (b != 0)
                                           : (a[W-1] != b[W-1]);
    side0.dz  = (cmd == fxalu_pkg::CMD_DIV) && (b == 0);
  end

  // stage 1 registers: magnitudes
  fxalu_pkg::fxa_side_t side1_r;
  logic [W-1:0] ma1_r, mb1_r;
  logic         v1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
    if (en) begin
      side1_r <= side0;
      ma1_r   <= ma;
      mb1_r   <= mb;
    end
  end

  // stage 2: unsigned magnitude multiply, registered
  logic [2*W-1:0] prod2_r;
  always_ff @(posedge clk) if (en) prod2_r <= ma1_r * mb1_r;

  // divider: num = 2*|a|<<F + |b|, den = 2|b|; quo = num / den is the rounded quotient
  logic [DW-1:0]  dnum;
  logic [W:0]     dden;
  logic [DW-1:0]  quo;
  logic [W+1:0]   drem;
  assign dnum = (DW'(ma1_r) << (FRAC_BITS + 1)) + DW'(mb1_r);
  assign dden = {mb1_r, 1'b0};
  fxalu_div #(.NumW(DW), .DenW(W+1)) u_div (
    .clk(clk), .en(en), .num(dnum), .den(dden), .quo(quo), .rem(drem)
  );

  // side info and product delay line matching divider latency
  fxalu_pkg::fxa_side_t sd_r [DW];
  logic [DW-1:0] vd_r;
  logic [2*W-1:0] pd_r [DW-1];
  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= '0;
    else if (en) vd_r <= {vd_r[DW-2:0], v1_r};
    if (en) begin
      sd_r[0] <= side1_r;
      for (int i = 1; i < DW; i++) sd_r[i] <= sd_r[i-1];
      pd_r[0] <= prod2_r;
      for (int i = 1; i < DW - 1; i++) pd_r[i] <= pd_r[i-1];
    end
  end

  // final stage: round, sign, saturate, select
  fxalu_pkg::fxa_side_t sf;
  logic [2*W-1:0] pm, pr;
  logic [DW-1:0]  mag;
  logic [W-1:0]   res;
  logic           sat;
  always_comb begin
    sf  = sd_r[DW-1];
    pm  = pd_r[DW-2];
    pr  = (pm + ((2*W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    mag = (sf.cmd == fxalu_pkg::CMD_MUL) ? DW'(pr) : quo;
    if (sf.cmd == fxalu_pkg::CMD_MUL && pr[2*W-1:DW] != '0) mag = '1;
    res = sf.simple_res;
    sat = sf.simple_sat;
    if ((sf.cmd == fxalu_pkg::CMD_MUL) || (sf.cmd == fxalu_pkg::CMD_DIV && !sf.dz)) begin
      if (sf.neg) begin
        if (mag > (DW'(1) << (W-1))) begin
          sat = 1'b1;
          res = 32'h80000000;
        end else res = W'(-mag);
      end else begin
        if (mag > DW'(32'h7fffffff)) begin
          sat = 1'b1;
          res = 32'h7fffffff;
        end else res = mag[W-1:0];
      end
    end else if (sf.cmd == fxalu_pkg::CMD_DIV) begin
      res = '0;
      sat = 1'b0;
    end
  end

  // output register
  logic        ov_r;
  logic [63:0] od_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= vd_r[DW-1];
    if (en) od_r <= {3'd0, sat, sf.dz, sf.int_part, sf.eq, sf.lt, sf.gt, res};
  end
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // unused upper input bits and divider remainder
  logic unused_in;
  assign unused_in = ^{in_tdata[71:68], drem};
endmodule

/* src/fxalu_div.sv */
// Pipelined restoring divider: one quotient bit per stage, skewed registers.
// Stage count is NumW; the whole pipe advances on en.
module fxalu_div #(
  parameter int NumW = 48,
  parameter int DenW = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic [NumW-1:0] quo,
  output logic [DenW:0]   rem
);
  // stage s registers hold the state after quotient bit NumW-1-s
  logic [NumW-1:0] n_r [NumW];
  logic [NumW-1:0] q_r [NumW];
  logic [DenW:0]   r_r [NumW];
  logic [DenW-1:0] d_r [NumW];

  // inputs seen by each stage
  logic [NumW-1:0] n_in    [NumW];
  logic [NumW-1:0] q_in    [NumW];
  logic [DenW:0]   r_in    [NumW];
  logic [DenW-1:0] d_in    [NumW];
  logic [DenW:0]   shifted [NumW];
  logic [DenW+1:0] trial   [NumW];

  // shift in the next numerator bit and try the subtraction
  always_comb begin
    n_in[0] = num;
    q_in[0] = '0;
    r_in[0] = '0;
    d_in[0] = den;
    for (int s = 1; s < NumW; s++) begin
      n_in[s] = n_r[s-1];
      q_in[s] = q_r[s-1];
      r_in[s] = r_r[s-1];
      d_in[s] = d_r[s-1];
    end
    for (int s = 0; s < NumW; s++) begin
      shifted[s] = {r_in[s][DenW-1:0], n_in[s][NumW-1-s]};
      trial[s]   = {1'b0, shifted[s]} - {2'b00, d_in[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NumW; s++) begin
        n_r[s] <= n_in[s];
        d_r[s] <= d_in[s];
        if (!trial[s][DenW+1]) begin
          r_r[s] <= trial[s][DenW:0];
          q_r[s] <= q_in[s] | (NumW'(1) << (NumW-1-s));
        end else begin
          r_r[s] <= shifted[s];
          q_r[s] <= q_in[s];
        end
      end
    end
  end

  assign quo = q_r[NumW-1];
  assign rem = r_r[NumW-1];
endmodule

/* src/fxalu_checker.sv */
`include "fixed_point_q24_8_alu_defines.svh"
module fxalu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);
  // a held result keeps its payload
  `FXA_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // input is blocked while a result is stalled
  `FXA_ASSERT_IMP(a_stall, clk, rst_n, out_tvalid && !out_tready, !in_tready)
  // exactly one comparison flag is set
  `FXA_ASSERT_IMP(a_cmp, clk, rst_n, out_tvalid, $onehot(out_tdata[34:32]))
  // divide by zero never saturates
  `FXA_ASSERT_IMP(a_dz, clk, rst_n, out_tvalid && out_tdata[59], !out_tdata[60])
endmodule

bind fixed_point_q24_8_alu fxalu_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

/* tb/sv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = fxalu_pkg::DivW + 2;
  localparam int LIMIT   = 400000;

  // first member lands in the high bits, so fields are listed top down
  typedef struct packed {
    logic [31:0]                op_b;
    logic [31:0]                op_a;
    logic [fxalu_pkg::CmdW-1:0] cmd;
  } alu_req_t;

  typedef struct packed {
    logic                           sat;
    logic                           dz;
    logic [fxalu_pkg::IntPartW-1:0] int_part;
    logic                           eq;
    logic                           lt;
    logic                           gt;
    logic [31:0]                    value;
  } alu_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int       error_count;
  int       cycle_count;
  bit       stim_done;
  bit       hold_long;
  int       in_gap;
  int       out_gap;
  int       hold_cycles;

  fixed_point_q24_8_alu u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Signed magnitude back to a 32-bit word, clamped
  function automatic logic [31:0] clamp_mag(input bit neg, input logic [63:0] m,
                                            inout bit sat);
    if (neg) begin
      if (m > 64'h8000_0000) begin
        sat = 1'b1;
        m = 64'h8000_0000;
      end
      return 32'(-m);
    end
    if (m > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      m = 64'h7FFF_FFFF;
    end
    return m[31:0];
  endfunction

  function automatic logic [31:0] clamp_wide(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Q24.8 ALU prediction
  function automatic alu_res_t alu_compute(input alu_req_t r);
    alu_res_t   res;
    longint     a;
    longint     b;
    longint     p;
    logic [63:0] m;
    logic [63:0] n;
    logic [63:0] d;
    bit         sat;
    a = longint'($signed(r.op_a));
    b = longint'($signed(r.op_b));
    sat = 1'b0;
    res = '0;
    case (r.cmd)
      fxalu_pkg::CMD_ADD: res.value = clamp_wide(a + b, sat);
      fxalu_pkg::CMD_SUB: res.value = clamp_wide(a - b, sat);
      fxalu_pkg::CMD_MUL: begin
        p = a * b;
        m = (p < 0) ? -p : p;
        m = (m + (64'd1 << (fxalu_pkg::FracBitsDefault - 1))) >> fxalu_pkg::FracBitsDefault;
        res.value = clamp_mag(p < 0, m, sat);
      end
      fxalu_pkg::CMD_DIV: begin
        if (b == 0) begin
          res.dz = 1'b1;
        end else begin
          n = ((a < 0) ? -a : a) << fxalu_pkg::FracBitsDefault;
          d = (b < 0) ? -b : b;
          m = (2 * n + d) / (2 * d);
          res.value = clamp_mag((a < 0) != (b < 0), m, sat);
        end
      end
      fxalu_pkg::CMD_MIN: res.value = (a < b) ? r.op_a : r.op_b;
      fxalu_pkg::CMD_MAX: res.value = (a > b) ? r.op_a : r.op_b;
      fxalu_pkg::CMD_INC: res.value = clamp_wide(a + 1, sat);
      fxalu_pkg::CMD_DEC: res.value = clamp_wide(a - 1, sat);
      fxalu_pkg::CMD_FINT:
        res.value = clamp_wide(a * (64'sd1 <<< fxalu_pkg::FracBitsDefault), sat);
      default: res.value = '0;
    endcase
    res.gt = a > b;
    res.lt = a < b;
    res.eq = a == b;
    p = a / (64'sd1 <<< fxalu_pkg::FracBitsDefault);
    res.int_part = p[fxalu_pkg::IntPartW-1:0];
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
      1: return 32'h8000_0000 + $urandom_range(0, 2);
      2: return 32'($signed($urandom_range(0, 1024)) - 512);
      3: return 32'($urandom_range(0, 8)) << 8;
      4: return 32'($signed($urandom_range(0, 65535)) - 32768) << 8;
      5: return $urandom_range(0, 1) ? 32'(1 << $urandom_range(0, 31)) : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(input logic [fxalu_pkg::CmdW-1:0] c, input logic [31:0] a,
                          input logic [31:0] b);
    alu_req_t r;
    r.cmd = c;
    r.op_a = a;
    r.op_b = b;
    pending_reqs.push_back(r);
  endtask

  // Stimulus: directed corners, then random
  initial begin
    alu_req_t r;
    logic [31:0] a;
    push_req(fxalu_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
    push_req(fxalu_pkg::CMD_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
    push_req(fxalu_pkg::CMD_SUB, 32'h8000_0000, 32'h0000_0001);
    push_req(fxalu_pkg::CMD_SUB, 32'h7FFF_FFFF, 32'h8000_0000);
    push_req(fxalu_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    push_req(fxalu_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'h8000_0000);
    push_req(fxalu_pkg::CMD_MUL, 32'h0000_0180, 32'h0000_0001);
    push_req(fxalu_pkg::CMD_MUL, 32'hFFFF_FE80, 32'h0000_0001);
    push_req(fxalu_pkg::CMD_DIV, 32'h0000_0100, 32'h0000_0000);
    push_req(fxalu_pkg::CMD_DIV, 32'h8000_0000, 32'h0000_0000);
    push_req(fxalu_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    push_req(fxalu_pkg::CMD_DIV, 32'h0000_0001, 32'h0000_0200);
    push_req(fxalu_pkg::CMD_DIV, 32'hFFFF_FFFF, 32'h0000_0200);
    push_req(fxalu_pkg::CMD_MIN, 32'h1234_5678, 32'h1234_5678);
    push_req(fxalu_pkg::CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
    push_req(fxalu_pkg::CMD_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
    push_req(fxalu_pkg::CMD_INC, 32'h7FFF_FFFF, 32'h0);
    push_req(fxalu_pkg::CMD_DEC, 32'h8000_0000, 32'h0);
    push_req(fxalu_pkg::CMD_FINT, 32'h0080_0000, 32'h0);
    push_req(fxalu_pkg::CMD_FINT, 32'hFF80_0000, 32'h0);
    push_req(fxalu_pkg::CMD_FINT, 32'hFF7F_FFFF, 32'hFFFF_FFFF);
    push_req(4'd9, 32'hFFFF_FF01, 32'h0);
    push_req(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 1200; i++) begin
      a = pick_operand();
      r.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8));
      r.op_b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
      r.op_a = a;
      if (r.cmd == fxalu_pkg::CMD_DIV && $urandom_range(0, 7) == 0)
        r.op_b = '0;
      pending_reqs.push_back(r);
    end
  end

  // Reset and cycle count
  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout");
      $display("FAIL");
      $finish;
    end
  end

  // Driver
  always @(posedge clk) begin
    alu_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid)
        expected_results.push_back(alu_compute(in_tdata[67:0]));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {4'b0, r.op_b, r.op_a, r.cmd};
        case ($urandom_range(0, 15))
          0: in_gap <= $urandom_range(10, 60);
          1, 2, 3: in_gap <= $urandom_range(1, 3);
          default: in_gap <= 0;
        endcase
      end else begin
        in_tvalid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Receiver: random stalls plus one long hold once traffic is flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
      hold_long <= 1'b0;
      hold_cycles <= 0;
    end else if (!hold_long && hold_cycles == 0 && cycle_count > 500) begin
      hold_long <= 1'b1;
      out_tready <= 1'b0;
    end else if (hold_long) begin
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 300) begin
        hold_long <= 1'b0;
        out_tready <= 1'b1;
      end
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      case ($urandom_range(0, 15))
        0: out_gap <= $urandom_range(10, 60);
        1, 2, 3: out_gap <= $urandom_range(1, 3);
        default: out_gap <= 0;
      endcase
    end
  end

  // Monitor
  always @(posedge clk) begin
    alu_res_t got;
    alu_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[60:0];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", got.value, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.value !== want.value) report_mismatch("result", got.value, want.value);
        if (got.gt !== want.gt) report_mismatch("a_greater", got.gt, want.gt);
        if (got.lt !== want.lt) report_mismatch("a_less", got.lt, want.lt);
        if (got.eq !== want.eq) report_mismatch("a_equal", got.eq, want.eq);
        if (got.int_part !== want.int_part)
          report_mismatch("integer_part", got.int_part, want.int_part);
        if (got.dz !== want.dz) report_mismatch("divide_by_zero", got.dz, want.dz);
        if (got.sat !== want.sat) report_mismatch("saturated", got.sat, want.sat);
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    wait (expected_results.size() == 0);
    repeat (2 * LATENCY) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
